// ----- src/gcm_pkg.sv -----
// types, constants and widths shared by the grid centre-of-mass block
`default_nettype none
package gcm_pkg;

  // default parameter values
  localparam int MAX_DIM_DEF   = 256;
  localparam int MASS_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  // fixed widths of the accumulators and results
  localparam int MOM_BITS  = 48;
  localparam int TOT_BITS  = 40;
  localparam int OUT_BITS  = 16;
  localparam int STEP_BITS = $clog2(OUT_BITS);

  // configuration port
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 9;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_ROWS = 4'd0,
    REG_GRID_COLS = 4'd1
  } reg_idx_t;

  localparam logic [CFG_DATA_BITS-1:0] GRID_ROWS_RST = 9'd4;
  localparam logic [CFG_DATA_BITS-1:0] GRID_COLS_RST = 9'd4;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_STEP,
    S_STORE,
    S_OUT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic store;
    logic sel_col;
    logic publish;
  } gcm_cmd_t;

endpackage
`default_nettype wire

// ----- src/gcm_if.sv -----
// valid/ready channel interfaces for input, result and configuration items
`default_nettype none
interface gcm_in_if #(
  parameter int MASS_BITS = gcm_pkg::MASS_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [MASS_BITS-1:0] mass;

  modport source (output valid, output mass, input ready);
  modport sink (input valid, input mass, output ready);
endinterface

interface gcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [gcm_pkg::OUT_BITS-1:0]  centre_row;
  logic [gcm_pkg::OUT_BITS-1:0]  centre_col;
  logic                          zero_mass;

  modport source (output valid, output centre_row, output centre_col, output zero_mass,
                  input ready);
  modport sink (input valid, input centre_row, input centre_col, input zero_mass,
                output ready);
endinterface

interface gcm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gcm_pkg::CFG_IDX_BITS-1:0]  index;
  logic [gcm_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/grid_centre_of_mass.sv -----
// top level of the grid centre-of-mass block
// Point masses enter on in_item, one item per grid node in row-major order.
// The grid size comes from cfg_wr (index 0 rows, index 1 columns, each 1..256;
// zero acts as one, larger values as the maximum); write it only while idle.
// After the last node of a grid one item leaves on out_item: the row and
// column centre in unsigned fixed point with FRAC_BITS fraction bits,
// saturated to 16 bits, or zero coordinates with zero_mass set when the
// grid's total mass is zero.
// Items are taken one per cycle while no grid end waits. After the last
// node a single restoring divider, one quotient bit per cycle, serves the
// row and then the column quotient (1 load, 16 steps, 1 store each), then the
// output register loads. Nodes of the next grid keep flowing during the
// division; only the last node of a grid waits until the divider is free, so a
// grid of 38 or more nodes runs at one item per cycle.
// The output register holds its item while out_item.ready is low; the divider
// then holds its quotients and the next grid end waits.
// Reset (synchronous, rst_n low) clears position and sums, drops any pending
// result and sets the grid to 4 by 4. cfg_wr is always ready.
`default_nettype none
module grid_centre_of_mass #(
  parameter int MAX_DIM   = gcm_pkg::MAX_DIM_DEF,
  parameter int MASS_BITS = gcm_pkg::MASS_BITS_DEF,
  parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  gcm_in_if.sink     in_item,
  gcm_out_if.source  out_item,
  gcm_cfg_if.sink    cfg_wr
);

  gcm_pkg::gcm_cmd_t cmd;
  logic grid_end;
  logic in_ready;
  logic out_valid;
  logic [MASS_BITS-1:0] mass;

  assign mass           = in_item.mass;
  assign in_item.ready  = in_ready;
  assign out_item.valid = out_valid;
  assign cfg_wr.ready   = 1'b1;

  // sequencing
  gcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .out_ready (out_item.ready),
    .grid_end  (grid_end),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // accumulation and division
  gcm_dp #(
    .MAX_DIM   (MAX_DIM),
    .MASS_BITS (MASS_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .mass       (mass),
    .cfg_we     (cfg_wr.valid),
    .cfg_index  (cfg_wr.index),
    .cfg_data   (cfg_wr.data),
    .grid_end   (grid_end),
    .centre_row (out_item.centre_row),
    .centre_col (out_item.centre_col),
    .zero_mass  (out_item.zero_mass)
  );

endmodule
`default_nettype wire

// ----- src/gcm_ctrl.sv -----
// controller: handshakes and sequencing of the shared divider
`default_nettype none
module gcm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_ready,
  input  wire logic              grid_end,
  output gcm_pkg::gcm_cmd_t      cmd,
  output logic                   in_ready,
  output logic                   out_valid
);

  gcm_pkg::state_t state_r, state_nxt;
  logic [gcm_pkg::STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic sel_r, sel_nxt;
  logic out_valid_r, out_valid_nxt;
  logic busy;
  logic start;

  // an item that ends a grid waits until the divider is free
  always_comb begin
    busy     = (state_r != gcm_pkg::S_IDLE);
    in_ready = !busy || !grid_end;
    start    = in_valid && in_ready && grid_end;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcm_pkg::S_IDLE: begin
        if (start) state_nxt = gcm_pkg::S_LOAD;
      end
      gcm_pkg::S_LOAD: begin
        state_nxt = gcm_pkg::S_STEP;
      end
      gcm_pkg::S_STEP: begin
        if (cnt_r == gcm_pkg::STEP_BITS'(gcm_pkg::OUT_BITS - 1)) state_nxt = gcm_pkg::S_STORE;
      end
      gcm_pkg::S_STORE: begin
        if (sel_r) state_nxt = gcm_pkg::S_OUT;
        else state_nxt = gcm_pkg::S_LOAD;
      end
      gcm_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = gcm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = gcm_pkg::S_IDLE;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.accept  = in_valid && in_ready;
    cmd.load    = (state_r == gcm_pkg::S_LOAD);
    cmd.step    = (state_r == gcm_pkg::S_STEP);
    cmd.store   = (state_r == gcm_pkg::S_STORE);
    cmd.sel_col = sel_r;
    cmd.publish = (state_r == gcm_pkg::S_OUT) && (!out_valid_r || out_ready);
    out_valid   = out_valid_r;
  end

  // step counter, row/column select and result valid
  always_comb begin
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    if (state_r == gcm_pkg::S_LOAD) cnt_nxt = '0;
    else if (state_r == gcm_pkg::S_STEP) cnt_nxt = cnt_r + 1'b1;
    if (start) sel_nxt = 1'b0;
    else if (state_r == gcm_pkg::S_STORE) sel_nxt = 1'b1;
    if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcm_pkg::S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/gcm_dp.sv -----
// datapath: grid position, moment accumulation, divider and result register
`default_nettype none
module gcm_dp #(
  parameter int MAX_DIM   = gcm_pkg::MAX_DIM_DEF,
  parameter int MASS_BITS = gcm_pkg::MASS_BITS_DEF,
  parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gcm_pkg::gcm_cmd_t                 cmd,
  input  wire logic [MASS_BITS-1:0]              mass,
  input  wire logic                              cfg_we,
  input  wire logic [gcm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [gcm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                                   grid_end,
  output logic [gcm_pkg::OUT_BITS-1:0]           centre_row,
  output logic [gcm_pkg::OUT_BITS-1:0]           centre_col,
  output logic                                   zero_mass
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int MOM_W = gcm_pkg::MOM_BITS;
  localparam int TOT_W = gcm_pkg::TOT_BITS;
  localparam int OUT_W = gcm_pkg::OUT_BITS;
  localparam int DIV_W = MOM_W + FRAC_BITS;
  localparam int CMP_W = DIV_W + TOT_W;

  logic [gcm_pkg::CFG_DATA_BITS-1:0] grid_rows_r, grid_cols_r;
  logic [POS_W-1:0] row_pos_r, col_pos_r, row_pos_nxt, col_pos_nxt;
  logic [POS_W-1:0] last_row, last_col;
  logic [MOM_W-1:0] row_mom_r, col_mom_r, row_mom_sum, col_mom_sum;
  logic [TOT_W-1:0] total_r, total_sum;
  logic row_end;

  logic [MOM_W-1:0] snap_row_r, snap_col_r;
  logic [TOT_W-1:0] snap_tot_r;

  logic [DIV_W-1:0] dvd;
  logic             sat_load;
  logic [TOT_W-1:0] rem_r;
  logic [OUT_W-1:0] lo_r, quo_r;
  logic             sat_r;
  logic [TOT_W:0]   trial;
  logic             trial_ge;
  logic [OUT_W-1:0] res_row_r, res_col_r, res_val;
  logic [OUT_W-1:0] out_row_r, out_col_r;
  logic             out_zero_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= gcm_pkg::GRID_ROWS_RST;
      grid_cols_r <= gcm_pkg::GRID_COLS_RST;
    end else if (cfg_we) begin
      if (cfg_index == gcm_pkg::REG_GRID_ROWS) grid_rows_r <= cfg_data;
      else if (cfg_index == gcm_pkg::REG_GRID_COLS) grid_cols_r <= cfg_data;
    end
  end

  // last row and column index, zero acting as one and clamped to the maximum
  always_comb begin
    if (grid_rows_r == '0) last_row = '0;
    else if (32'(grid_rows_r) > 32'(MAX_DIM)) last_row = POS_W'(MAX_DIM - 1);
    else last_row = POS_W'(grid_rows_r - 1'b1);
    if (grid_cols_r == '0) last_col = '0;
    else if (32'(grid_cols_r) > 32'(MAX_DIM)) last_col = POS_W'(MAX_DIM - 1);
    else last_col = POS_W'(grid_cols_r - 1'b1);
  end

  // position tracking
  always_comb begin
    row_end  = (col_pos_r >= last_col);
    grid_end = row_end && (row_pos_r >= last_row);
    col_pos_nxt = row_end ? '0 : col_pos_r + 1'b1;
    if (!row_end) row_pos_nxt = row_pos_r;
    else if (grid_end) row_pos_nxt = '0;
    else row_pos_nxt = row_pos_r + 1'b1;
  end

  // moment and total sums including the current item
  always_comb begin
    row_mom_sum = row_mom_r + MOM_W'(row_pos_r * mass);
    col_mom_sum = col_mom_r + MOM_W'(col_pos_r * mass);
    total_sum   = total_r + TOT_W'(mass);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      row_mom_r <= '0;
      col_mom_r <= '0;
      total_r   <= '0;
    end else if (cmd.accept) begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      if (grid_end) begin
        row_mom_r <= '0;
        col_mom_r <= '0;
        total_r   <= '0;
      end else begin
        row_mom_r <= row_mom_sum;
        col_mom_r <= col_mom_sum;
        total_r   <= total_sum;
      end
    end
  end

  // sums of a finished grid, held for the divider
  always_ff @(posedge clk) begin
    if (cmd.accept && grid_end) begin
      snap_row_r <= row_mom_sum;
      snap_col_r <= col_mom_sum;
      snap_tot_r <= total_sum;
    end
  end

  // divider set-up: a quotient that cannot fit the result width saturates
  always_comb begin
    dvd      = DIV_W'(cmd.sel_col ? snap_col_r : snap_row_r) << FRAC_BITS;
    sat_load = (CMP_W'(dvd >> OUT_W) >= CMP_W'(snap_tot_r));
    trial    = {rem_r, lo_r[OUT_W-1]};
    trial_ge = (trial >= {1'b0, snap_tot_r});
    res_val  = sat_r ? '1 : quo_r;
  end

  // restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= TOT_W'(dvd >> OUT_W);
      lo_r  <= OUT_W'(dvd);
      quo_r <= '0;
      sat_r <= sat_load;
    end else if (cmd.step) begin
      rem_r <= trial_ge ? TOT_W'(trial - {1'b0, snap_tot_r}) : TOT_W'(trial);
      lo_r  <= lo_r << 1;
      quo_r <= {quo_r[OUT_W-2:0], trial_ge};
    end
  end

  // quotient hold registers
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (cmd.sel_col) res_col_r <= res_val;
      else res_row_r <= res_val;
    end
  end

  // result register, zero total forces zero coordinates
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_zero_r <= (snap_tot_r == '0);
      out_row_r  <= (snap_tot_r == '0) ? '0 : res_row_r;
      out_col_r  <= (snap_tot_r == '0) ? '0 : res_col_r;
    end
  end

  assign centre_row = out_row_r;
  assign centre_col = out_col_r;
  assign zero_mass  = out_zero_r;

endmodule
`default_nettype wire
